// ----- rtl/bdq_pkg.sv -----
package bdq_pkg;

    localparam int CAPACITY   = 256;
    localparam int COORD_BITS = 8;

    localparam int PTR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIDE_W = (CNT_W > 9) ? CNT_W : 9;

    localparam logic [7:0] COORD_MASK =
        (COORD_BITS >= 8) ? 8'hFF : 8'((1 << COORD_BITS) - 1);

    localparam logic [2:0] OP_INS_HEAD = 3'd0;
    localparam logic [2:0] OP_INS_TAIL = 3'd1;
    localparam logic [2:0] OP_REM_HEAD = 3'd2;
    localparam logic [2:0] OP_REM_TAIL = 3'd3;
    localparam logic [2:0] OP_RD_HEAD  = 3'd4;
    localparam logic [2:0] OP_RD_TAIL  = 3'd5;
    localparam logic [2:0] OP_RD_IDX   = 3'd6;
    localparam logic [2:0] OP_FIND     = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] x_coord;
        logic [7:0] y_coord;
        logic [7:0] glyph;
        logic [7:0] read_index;
        logic       strict_match;
    } bdq_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_x;
        logic [7:0] out_y;
        logic [7:0] out_glyph;
        logic [7:0] found_at;
        logic [8:0] entry_count;
    } bdq_rsp_t;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] glyph;
    } bdq_entry_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_RDATA = 5'b00100,
        S_SCAN  = 5'b01000,
        S_OUT   = 5'b10000
    } bdq_state_t;

    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(head) + (CNT_W + 1)'(pos);
        if (s >= (CNT_W + 1)'(CAPACITY))
        begin
            s = s - (CNT_W + 1)'(CAPACITY);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

// ----- rtl/bdq_if.sv -----
interface bdq_req_if;
    logic               valid;
    logic               ready;
    bdq_pkg::bdq_req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bdq_rsp_if;
    logic               valid;
    logic               ready;
    bdq_pkg::bdq_rsp_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/bdq_ram.sv -----
module bdq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bdq_match.sv -----
module bdq_match (
    input  bdq_pkg::bdq_entry_t entry,
    input  bdq_pkg::bdq_req_t   req,
    output logic                hit
);
    import bdq_pkg::*;

    logic xy_eq;
    logic glyph_eq;

    assign xy_eq    = (entry.x == req.x_coord) && (entry.y == req.y_coord);
    assign glyph_eq = (entry.glyph == req.glyph);
    assign hit      = xy_eq && (!req.strict_match || glyph_eq);

endmodule

// ----- rtl/bounded_deque_with_position_search_top.sv -----
// From item accept, the sequencer steps through EXEC then OUT for inserts and errors,
// EXEC, RDATA, OUT for removes and reads, and EXEC, SCAN, OUT for find, where SCAN
// runs up to the matched position, or to the last entry on a miss, and find
// compares one stored entry per cycle. A new item is accepted only once the result is taken.
// Reset clears head pointer, count and sequencer; entry RAM is not cleared.
module bounded_deque_with_position_search_top (
    input  logic       clk,
    input  logic       rst_n,
    bdq_req_if.sink    req,
    bdq_rsp_if.source  rsp
);
    import bdq_pkg::*;

    bdq_state_t         state_reg, state_next;
    bdq_req_t           req_reg, req_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [2:0]         status_reg, status_next;
    bdq_entry_t         entry_reg, entry_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;

    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    bdq_entry_t         ram_wdata;
    logic [PTR_W-1:0]   ram_raddr;
    bdq_entry_t         ram_rdata;
    logic               hit;

    logic               empty;
    logic               full;
    logic [PTR_W-1:0]   head_dec;
    logic [PTR_W-1:0]   head_inc;
    logic [CNT_W-1:0]   last_pos;
    logic [CNT_W-1:0]   idx_inc;
    logic [WIDE_W-1:0]  rd_idx_wide;
    logic [WIDE_W-1:0]  count_wide;
    logic [WIDE_W-1:0]  pos_wide;

    bdq_ram #(
        .WIDTH ($bits(bdq_entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bdq_match u_match (
        .entry (ram_rdata),
        .req   (req_reg),
        .hit   (hit)
    );

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign head_dec = (head_reg == '0) ? PTR_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == PTR_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
    assign last_pos = count_reg - 1'b1;
    assign idx_inc  = idx_reg + 1'b1;

    assign rd_idx_wide = WIDE_W'(req_reg.read_index);
    assign count_wide  = WIDE_W'(count_reg);
    assign pos_wide    = WIDE_W'(pos_reg);

    assign ram_wdata.x     = req_reg.x_coord;
    assign ram_wdata.y     = req_reg.y_coord;
    assign ram_wdata.glyph = req_reg.glyph;

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        entry_next  = entry_reg;
        pos_next    = pos_reg;
        ram_we      = 1'b0;
        ram_waddr   = head_reg;
        ram_raddr   = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next         = req.data;
                    req_next.x_coord = req.data.x_coord & COORD_MASK;
                    req_next.y_coord = req.data.y_coord & COORD_MASK;
                    state_next       = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                entry_next  = '0;
                pos_next    = '0;
                state_next  = S_OUT;
                case (req_reg.op)
                    OP_INS_HEAD,
                    OP_INS_TAIL:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            if (req_reg.op == OP_INS_HEAD)
                            begin
                                head_next = head_dec;
                                ram_waddr = head_dec;
                            end
                            else
                            begin
                                ram_waddr = slot_of(head_reg, count_reg);
                            end
                        end
                    end
                    OP_REM_HEAD:
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_raddr  = head_reg;
                            head_next  = head_inc;
                            count_next = last_pos;
                            state_next = S_RDATA;
                        end
                    end
                    OP_REM_TAIL:
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_raddr  = slot_of(head_reg, last_pos);
                            count_next = last_pos;
                            pos_next   = last_pos;
                            state_next = S_RDATA;
                        end
                    end
                    OP_RD_HEAD:
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_raddr  = head_reg;
                            state_next = S_RDATA;
                        end
                    end
                    OP_RD_TAIL:
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_raddr  = slot_of(head_reg, last_pos);
                            pos_next   = last_pos;
                            state_next = S_RDATA;
                        end
                    end
                    OP_RD_IDX:
                    begin
                        if (rd_idx_wide >= count_wide)
                        begin
                            status_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            ram_raddr  = slot_of(head_reg, CNT_W'(rd_idx_wide));
                            pos_next   = CNT_W'(rd_idx_wide);
                            state_next = S_RDATA;
                        end
                    end
                    default:
                    begin
                        if (empty)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            ram_raddr  = head_reg;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end
            S_RDATA:
            begin
                entry_next = ram_rdata;
                state_next = S_OUT;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    status_next = ST_OK;
                    entry_next  = ram_rdata;
                    pos_next    = idx_reg;
                    state_next  = S_OUT;
                end
                else if (idx_inc == count_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_OUT;
                end
                else
                begin
                    idx_next  = idx_inc;
                    ram_raddr = slot_of(head_reg, idx_inc);
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        entry_reg  <= entry_next;
        pos_reg    <= pos_next;
    end

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid            = (state_reg == S_OUT);
    assign rsp.data.status      = status_reg;
    assign rsp.data.out_x       = entry_reg.x;
    assign rsp.data.out_y       = entry_reg.y;
    assign rsp.data.out_glyph   = entry_reg.glyph;
    assign rsp.data.found_at    = pos_wide[7:0];
    assign rsp.data.entry_count = count_wide[8:0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !rsp.valid)
        else $error("input ready while result pending");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_reg < count_reg))
        else $error("scan index past entry count");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready) |=> req.ready)
        else $error("not idle after result taken");

endmodule

// ----- test/testbench.sv -----
module testbench;
    import bdq_pkg::*;

    localparam int         HOLD_CYCLES   = 300;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         SETTLE_CYCLES = CAPACITY + 8;
    localparam logic [7:0] BLANK_GLYPH   = 8'h20;

    logic clk = 1'b0;
    logic rst_n;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_with_position_search_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mirror of the deque contents, updated in accept order
    bdq_entry_t  mirror_store [CAPACITY];
    int unsigned mirror_head  = 0;
    int unsigned mirror_count = 0;

    bdq_rsp_t    rsp_backlog [$];
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_requests = 0;
    int          failures      = 0;
    int          items_sent    = 0;
    int          rsp_checked   = 0;
    int          status_seen [5] = '{default: 0};
    int          quiet_cycles  = 0;

    function automatic int unsigned ring_slot(input int unsigned pos);
        return (mirror_head + pos) % CAPACITY;
    endfunction

    function automatic bdq_rsp_t entry_rsp(input bdq_entry_t e, input int unsigned pos);
        bdq_rsp_t r;
        r           = '0;
        r.status    = ST_OK;
        r.out_x     = e.x;
        r.out_y     = e.y;
        r.out_glyph = e.glyph;
        r.found_at  = 8'(pos);
        return r;
    endfunction

    function automatic bdq_rsp_t predict_response(input bdq_req_t item);
        bdq_rsp_t    r;
        bdq_entry_t  want;
        bdq_entry_t  got;
        int unsigned pos;
        bit          hit;
        r          = '0;
        want.x     = item.x_coord & COORD_MASK;
        want.y     = item.y_coord & COORD_MASK;
        want.glyph = item.glyph;
        case (item.op)
            OP_INS_HEAD, OP_INS_TAIL:
            begin
                if (mirror_count >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    if (item.op == OP_INS_HEAD)
                    begin
                        mirror_head = (mirror_head + CAPACITY - 1) % CAPACITY;
                        mirror_store[mirror_head] = want;
                    end
                    else
                    begin
                        mirror_store[ring_slot(mirror_count)] = want;
                    end
                    mirror_count++;
                    r.status = ST_OK;
                end
            end
            OP_REM_HEAD, OP_REM_TAIL:
            begin
                if (mirror_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (item.op == OP_REM_HEAD)
                begin
                    got = mirror_store[mirror_head];
                    mirror_head = (mirror_head + 1) % CAPACITY;
                    mirror_count--;
                    r = entry_rsp(got, 0);
                end
                else
                begin
                    mirror_count--;
                    got = mirror_store[ring_slot(mirror_count)];
                    r = entry_rsp(got, mirror_count);
                end
            end
            OP_RD_HEAD, OP_RD_TAIL:
            begin
                if (mirror_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    pos = (item.op == OP_RD_HEAD) ? 0 : mirror_count - 1;
                    r = entry_rsp(mirror_store[ring_slot(pos)], pos);
                end
            end
            OP_RD_IDX:
            begin
                if (item.read_index >= mirror_count)
                begin
                    r.status = ST_BAD_INDEX;
                end
                else
                begin
                    r = entry_rsp(mirror_store[ring_slot(item.read_index)], item.read_index);
                end
            end
            default:
            begin
                hit = 1'b0;
                r.status = ST_NOT_FOUND;
                for (pos = 0; pos < mirror_count; pos++)
                begin
                    got = mirror_store[ring_slot(pos)];
                    if (!hit && got.x == want.x && got.y == want.y &&
                        (!item.strict_match || got.glyph == want.glyph))
                    begin
                        hit = 1'b1;
                        r = entry_rsp(got, pos);
                    end
                end
            end
        endcase
        r.entry_count = 9'(mirror_count);
        return r;
    endfunction

    function automatic bdq_req_t make_item(input logic [2:0] op, input logic [7:0] x, y, g, idx,
                                           input logic strict);
        bdq_req_t item;
        item.op           = op;
        item.x_coord      = x;
        item.y_coord      = y;
        item.glyph        = g;
        item.read_index   = idx;
        item.strict_match = strict;
        return item;
    endfunction

    // op mix leans toward inserts below target fill and toward removes above it
    function automatic bdq_req_t random_item(input int unsigned target);
        bdq_req_t    item;
        bdq_entry_t  e;
        int unsigned roll;
        int unsigned ins_w;
        int unsigned pick;
        item = make_item(OP_FIND, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         1'($urandom));
        if ($urandom_range(0, 1))
        begin
            item.x_coord = 8'($urandom_range(0, 3));
            item.y_coord = 8'($urandom_range(0, 3));
        end
        roll  = $urandom_range(0, 99);
        ins_w = (mirror_count < target) ? 45 : 15;
        if (roll < ins_w)
        begin
            item.op = $urandom_range(0, 1) ? OP_INS_HEAD : OP_INS_TAIL;
        end
        else if (roll < 60)
        begin
            item.op = $urandom_range(0, 1) ? OP_REM_HEAD : OP_REM_TAIL;
        end
        else if (roll < 80)
        begin
            pick = $urandom_range(0, 2);
            item.op = (pick == 0) ? OP_RD_HEAD : (pick == 1) ? OP_RD_TAIL : OP_RD_IDX;
        end
        else if (mirror_count != 0 && $urandom_range(0, 99) < 60)
        begin
            e = mirror_store[ring_slot($urandom_range(0, mirror_count - 1))];
            item.x_coord = e.x;
            item.y_coord = e.y;
            if ($urandom_range(0, 1))
            begin
                item.glyph = e.glyph;
            end
        end
        if (mirror_count != 0 && $urandom_range(0, 99) < 70)
        begin
            item.read_index = 8'($urandom_range(0, mirror_count - 1));
        end
        return item;
    endfunction

    task automatic send_item(input bdq_req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        rsp_backlog.push_back(predict_response(item));
        items_sent++;
    endtask

    task automatic wait_for_backlog_empty();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (rsp_backlog.size() != 0);
    endtask

    task automatic run_random(input int n, input int unsigned target);
        repeat (n)
        begin
            send_item(random_item(target));
        end
    endtask

    task automatic test_empty_list();
        send_item(make_item(OP_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_REM_TAIL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_item(make_item(OP_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_RD_IDX, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_FIND, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
    endtask

    task automatic test_extremes();
        send_item(make_item(OP_INS_TAIL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        // head insert with the head at slot zero wraps the head to the last slot
        send_item(make_item(OP_INS_HEAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_item(make_item(OP_INS_TAIL, 8'hFF, 8'h00, BLANK_GLYPH, 8'h00, 1'b0));
        send_item(make_item(OP_INS_HEAD, 8'h00, 8'hFF, 8'hAA, 8'h55, 1'b1));
        send_item(make_item(OP_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_RD_IDX, 8'h00, 8'h00, 8'h00, 8'd2, 1'b0));
        send_item(make_item(OP_RD_IDX, 8'h00, 8'h00, 8'h00, 8'd4, 1'b0));
        send_item(make_item(OP_RD_IDX, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0));
        send_item(make_item(OP_FIND, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_FIND, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1));
        send_item(make_item(OP_FIND, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
        // same x and y, other glyph: strict find must skip the earlier entry
        send_item(make_item(OP_INS_TAIL, 8'hFF, 8'hFF, 8'h55, 8'h00, 1'b0));
        send_item(make_item(OP_FIND, 8'hFF, 8'hFF, 8'h55, 8'h00, 1'b1));
        send_item(make_item(OP_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_item(make_item(OP_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    endtask

    task automatic test_full_list();
        bdq_entry_t e;
        send_idle_pct = 14;
        stall_pct     = 14;
        while (mirror_count < CAPACITY)
        begin
            send_item(make_item($urandom_range(0, 1) ? OP_INS_HEAD : OP_INS_TAIL,
                                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                1'($urandom)));
        end
        send_item(make_item(OP_INS_HEAD, 8'h01, 8'h02, 8'h03, 8'h00, 1'b0));
        send_item(make_item(OP_INS_TAIL, 8'h01, 8'h02, 8'h03, 8'h00, 1'b0));
        send_item(make_item(OP_RD_IDX, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0));
        e = mirror_store[ring_slot(CAPACITY - 1)];
        send_item(make_item(OP_FIND, e.x, e.y, e.glyph, 8'h00, 1'b1));
        send_item(make_item(OP_FIND, e.x, e.y, ~e.glyph, 8'h00, 1'b0));
        send_item(make_item(OP_FIND, e.x, e.y, ~e.glyph, 8'h00, 1'b1));
        while (mirror_count != 0)
        begin
            send_item(make_item($urandom_range(0, 1) ? OP_REM_HEAD : OP_REM_TAIL,
                                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                1'($urandom)));
        end
        send_item(make_item(OP_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests++;
        run_random(12, 6);
        wait_for_backlog_empty();
        run_random(8, 6);
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(170, 8);
        send_idle_pct = 54;
        stall_pct     = 0;
        run_random(170, 30);
        send_idle_pct = 0;
        stall_pct     = 54;
        run_random(170, 60);
        send_idle_pct = 14;
        stall_pct     = 14;
        run_random(170, 16);
    endtask

    function automatic void check_field(input string name, input logic [8:0] want,
                                        input logic [8:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : rsp_check
        bdq_rsp_t want;
        bdq_rsp_t seen;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen = rsp_ch.data;
            if (rsp_backlog.size() == 0)
            begin
                $error("unexpected response, status %0d", seen.status);
                failures++;
            end
            else
            begin
                want = rsp_backlog.pop_front();
                check_field("status", 9'(want.status), 9'(seen.status));
                check_field("out_x", 9'(want.out_x), 9'(seen.out_x));
                check_field("out_y", 9'(want.out_y), 9'(seen.out_y));
                check_field("out_glyph", 9'(want.out_glyph), 9'(seen.out_glyph));
                check_field("found_at", 9'(want.found_at), 9'(seen.found_at));
                check_field("entry_count", want.entry_count, seen.entry_count);
                if (want.status <= ST_NOT_FOUND)
                begin
                    status_seen[want.status]++;
                end
                rsp_checked++;
            end
        end
    end

    initial
    begin : rsp_ready_drive
        int unsigned holds_served;
        holds_served = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                repeat (HOLD_CYCLES)
                begin
                    rsp_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("no handshake for %0d cycles, %0d responses outstanding",
                   quiet_cycles, rsp_backlog.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_extremes();
        test_full_list();
        test_backpressure();
        test_random_phases();
        wait_for_backlog_empty();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d items, checked %0d responses across empty, wrapped and full lists.",
                 items_sent, rsp_checked);
        $display("Status mix: ok %0d, full %0d, empty %0d, bad index %0d, not found %0d.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_BAD_INDEX], status_seen[ST_NOT_FOUND]);
        if (failures == 0 && rsp_backlog.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ----- bounded_deque_with_position_search_top.f -----
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bdq_ram.sv
rtl/bdq_match.sv
rtl/bounded_deque_with_position_search_top.sv
test/testbench.sv
